### src/pws_pkg.sv
// shared types, constants and saturation helper for the perspective projection block
package pws_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int WIN_BITS      = 15;
   localparam logic [WIN_BITS-1:0] WIN_W_RESET = 15'd1920;
   localparam logic [WIN_BITS-1:0] WIN_H_RESET = 15'd1080;

   // register indexes on the csr port
   localparam logic REG_WINDOW_WIDTH  = 1'b0;
   localparam logic REG_WINDOW_HEIGHT = 1'b1;

   // request modes
   localparam logic MODE_COEF    = 1'b0;
   localparam logic MODE_PROJECT = 1'b1;

   typedef struct packed {
      logic               mode;
      logic [3:0]         coef_index;
      logic signed [31:0] coef_value;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } req_type;

   typedef struct packed {
      logic               visible;
      logic signed [31:0] screen_x;
      logic signed [31:0] screen_y;
   } rsp_type;

   typedef struct packed {
      logic               vld;
      logic               vis;
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic signed [31:0] cw;
   } clip_type;

   typedef struct packed {
      logic               vld;
      logic               vis;
      logic signed [31:0] nx;
      logic signed [31:0] ny;
   } ndc_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v[63:31] == {33{1'b0}} || v[63:31] == {33{1'b1}}) begin
         r = v[31:0];
      end else if (v[63]) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'sh7fff_ffff;
      end
      return r;
   endfunction

endpackage

### src/pws_clip.sv
// matrix store and three-stage clip transform (multiply, floor and saturate, sum)
module pws_clip #(
   parameter int FRAC_BITS = pws_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_accept,
   input  pws_pkg::req_type  req_payload,
   output pws_pkg::clip_type clip_out
);

   localparam int THR = ((1 << FRAC_BITS) + 5) / 10;

   logic signed [31:0] mat_ff [16];

   logic               vld1_ff, vld2_ff, vld3_ff;
   logic signed [63:0] prod_in [9];
   logic signed [63:0] prod_ff [9];
   logic signed [31:0] fl_in   [9];
   logic signed [31:0] fl_ff   [9];
   logic signed [31:0] tr1_ff  [3];
   logic signed [31:0] tr2_ff  [3];
   logic signed [31:0] sum_in  [3];
   logic signed [31:0] sum_ff  [3];
   logic signed [31:0] pos     [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            mat_ff[i] <= '0;
         end
      end else if (in_accept && req_payload.mode == pws_pkg::MODE_COEF) begin
         mat_ff[req_payload.coef_index] <= req_payload.coef_value;
      end
   end

   // lanes 0, 1, 2 give clip x, y, w (matrix rows 0, 1, 3)
   always_comb begin
      pos[0] = req_payload.pos_x;
      pos[1] = req_payload.pos_y;
      pos[2] = req_payload.pos_z;
      for (int ln = 0; ln < 3; ln++) begin
         for (int k = 0; k < 3; k++) begin
            prod_in[ln*3+k] = mat_ff[((ln == 2) ? 3 : ln) + 4*k] * pos[k];
         end
      end
      for (int j = 0; j < 9; j++) begin
         fl_in[j] = pws_pkg::sat32(prod_ff[j] >>> FRAC_BITS);
      end
      for (int ln = 0; ln < 3; ln++) begin
         sum_in[ln] = pws_pkg::sat32(64'(fl_ff[ln*3]) + 64'(fl_ff[ln*3+1])
                                     + 64'(fl_ff[ln*3+2]) + 64'(tr2_ff[ln]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= in_accept && req_payload.mode == pws_pkg::MODE_PROJECT;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 9; j++) begin
            prod_ff[j] <= prod_in[j];
            fl_ff[j]   <= fl_in[j];
         end
         for (int ln = 0; ln < 3; ln++) begin
            tr1_ff[ln] <= mat_ff[((ln == 2) ? 3 : ln) + 12];
            tr2_ff[ln] <= tr1_ff[ln];
            sum_ff[ln] <= sum_in[ln];
         end
      end
   end

   always_comb begin
      clip_out.vld = vld3_ff;
      clip_out.cx  = sum_ff[0];
      clip_out.cy  = sum_ff[1];
      clip_out.cw  = sum_ff[2];
      clip_out.vis = sum_ff[2] >= $signed(32'(THR));
   end

endmodule

### src/pws_div.sv
// pipelined restoring divider, one quotient bit per stage, x and y lanes side by side
module pws_div #(
   parameter int FRAC_BITS = pws_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  pws_pkg::clip_type clip_in,
   output pws_pkg::ndc_type  ndc_out
);

   localparam int NW = 32 + FRAC_BITS;

   logic              vld_ff [NW+1];
   logic              vis_ff [NW+1];
   logic [31:0]       den_ff [NW+1];
   logic              neg_ff [NW+1][2];
   logic [31:0]       rem_ff [NW+1][2];
   logic [NW-1:0]     acc_ff [NW+1][2];

   logic [32:0]       trial [NW][2];
   logic [32:0]       diff  [NW][2];

   logic signed [31:0] num  [2];
   logic signed [31:0] res_in [2];
   logic signed [31:0] res_ff [2];
   logic              vldo_ff, viso_ff;

   assign num[0] = clip_in.cx;
   assign num[1] = clip_in.cy;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= NW; s++) begin
            vld_ff[s] <= 1'b0;
         end
         vldo_ff <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= clip_in.vld;
         for (int s = 1; s <= NW; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
         vldo_ff <= vld_ff[NW];
      end
   end

   // magnitude prep
   always_ff @(posedge clock) begin
      if (en) begin
         vis_ff[0] <= clip_in.vis;
         den_ff[0] <= clip_in.cw;
         for (int l = 0; l < 2; l++) begin
            neg_ff[0][l] <= num[l][31];
            rem_ff[0][l] <= '0;
            acc_ff[0][l] <= {(num[l][31] ? 32'(-num[l]) : 32'(num[l])),
                             {FRAC_BITS{1'b0}}};
         end
      end
   end

   for (genvar s = 0; s < NW; s++) begin : g_stage
      for (genvar l = 0; l < 2; l++) begin : g_lane
         assign trial[s][l] = {rem_ff[s][l], acc_ff[s][l][NW-1]};
         assign diff[s][l]  = trial[s][l] - {1'b0, den_ff[s]};
      end
      always_ff @(posedge clock) begin
         if (en) begin
            vis_ff[s+1] <= vis_ff[s];
            den_ff[s+1] <= den_ff[s];
            for (int l = 0; l < 2; l++) begin
               neg_ff[s+1][l] <= neg_ff[s][l];
               rem_ff[s+1][l] <= diff[s][l][32] ? trial[s][l][31:0] : diff[s][l][31:0];
               acc_ff[s+1][l] <= {acc_ff[s][l][NW-2:0], ~diff[s][l][32]};
            end
         end
      end
   end

   // sign and saturate the quotient
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         if (neg_ff[NW][l]) begin
            if (acc_ff[NW][l][NW-1:32] != '0
                || (acc_ff[NW][l][31] && acc_ff[NW][l][30:0] != '0)) begin
               res_in[l] = 32'sh8000_0000;
            end else begin
               res_in[l] = -$signed(acc_ff[NW][l][31:0]);
            end
         end else begin
            if (acc_ff[NW][l][NW-1:31] != '0) begin
               res_in[l] = 32'sh7fff_ffff;
            end else begin
               res_in[l] = $signed(acc_ff[NW][l][31:0]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         viso_ff   <= vis_ff[NW];
         res_ff[0] <= res_in[0];
         res_ff[1] <= res_in[1];
      end
   end

   always_comb begin
      ndc_out.vld = vldo_ff;
      ndc_out.vis = viso_ff;
      ndc_out.nx  = res_ff[0];
      ndc_out.ny  = res_ff[1];
   end

endmodule

### src/pws_view.sv
// viewport map: half-size multiply stage, then offset, saturate and output register
module pws_view #(
   parameter int FRAC_BITS = pws_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  pws_pkg::ndc_type              ndc_in,
   input  logic [pws_pkg::WIN_BITS-2:0]  half_w,
   input  logic [pws_pkg::WIN_BITS-2:0]  half_h,
   output logic                          out_valid,
   output pws_pkg::rsp_type              out_payload
);

   localparam int HB = pws_pkg::WIN_BITS - 1;

   logic               vld_ff, vis_ff, vldo_ff;
   logic signed [46:0] mx_in, my_in, mx_ff, my_ff;
   logic [HB-1:0]      hw_ff, hh_ff;
   logic signed [63:0] offx, offy;
   pws_pkg::rsp_type   rsp_in, rsp_ff;

   assign mx_in = $signed({1'b0, half_w}) * ndc_in.nx;
   assign my_in = $signed({1'b0, half_h}) * ndc_in.ny;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= 1'b0;
         vldo_ff <= 1'b0;
      end else if (en) begin
         vld_ff  <= ndc_in.vld;
         vldo_ff <= vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vis_ff <= ndc_in.vis;
         mx_ff  <= mx_in;
         my_ff  <= my_in;
         hw_ff  <= half_w;
         hh_ff  <= half_h;
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      offx = $signed({{(64-HB-FRAC_BITS){1'b0}}, hw_ff, {FRAC_BITS{1'b0}}});
      offy = $signed({{(64-HB-FRAC_BITS){1'b0}}, hh_ff, {FRAC_BITS{1'b0}}});
      rsp_in.visible = vis_ff;
      if (vis_ff) begin
         rsp_in.screen_x = pws_pkg::sat32(64'(mx_ff) + offx);
         rsp_in.screen_y = pws_pkg::sat32(offy - 64'(my_ff));
      end else begin
         rsp_in.screen_x = '0;
         rsp_in.screen_y = '0;
      end
   end

   assign out_valid   = vldo_ff;
   assign out_payload = rsp_ff;

endmodule

### src/perspective_world_to_screen.sv
// top level of the world-to-screen perspective projection pipeline
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  pws_pkg::req_type (coef write or point)
//   rsp_      out        rsp_valid / rsp_stall  pws_pkg::rsp_type (visible, screen x/y)
//   csr_      in         apb-style, pready = 1  window_width @0x0, window_height @0x4
//
// one request per cycle while not stalled; a point's result passes through three clip stages,
// 32 + FRAC_BITS divider bit stages plus two, and two viewport stages before it appears.
// the divider's one-bit-per-stage chain sets the latency.
// coefficient writes land at acceptance and give no result.
// reset is synchronous: pipeline valids and matrix are cleared, window registers return to their defaults.
// a stall on rsp_ while a result is waiting holds the whole pipeline and raises req_stall in the same cycle.
module perspective_world_to_screen #(
   parameter int FRAC_BITS = pws_pkg::FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pws_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pws_pkg::rsp_type rsp_payload,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic                           adv;
   logic                           req_accept;
   logic                           csr_wr;
   logic [pws_pkg::WIN_BITS-1:0]   win_w_ff, win_h_ff;
   pws_pkg::clip_type              clip;
   pws_pkg::ndc_type               ndc;

   // pipeline moves whenever the output slot is empty or being taken
   assign adv        = !rsp_valid || !rsp_stall;
   assign req_stall  = !adv;
   assign req_accept = req_valid && adv;

   // csr port, register index from paddr bit 2
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_w_ff <= pws_pkg::WIN_W_RESET;
         win_h_ff <= pws_pkg::WIN_H_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[2] == pws_pkg::REG_WINDOW_WIDTH) begin
            win_w_ff <= csr_pwdata[pws_pkg::WIN_BITS-1:0];
         end else begin
            win_h_ff <= csr_pwdata[pws_pkg::WIN_BITS-1:0];
         end
      end
   end

   always_comb begin
      case (csr_paddr[2])
         pws_pkg::REG_WINDOW_WIDTH:  csr_prdata = 32'(win_w_ff);
         pws_pkg::REG_WINDOW_HEIGHT: csr_prdata = 32'(win_h_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // matrix store and clip = M * (x, y, z, 1)
   pws_clip #(.FRAC_BITS(FRAC_BITS)) u_clip (
      .clock       (clock),
      .reset       (reset),
      .en          (adv),
      .in_accept   (req_accept),
      .req_payload (req_payload),
      .clip_out    (clip)
   );

   // ndc = clip * 2^FRAC_BITS / w for x and y
   pws_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (adv),
      .clip_in (clip),
      .ndc_out (ndc)
   );

   // pixels from ndc with integer half sizes; holds the output register
   pws_view #(.FRAC_BITS(FRAC_BITS)) u_view (
      .clock       (clock),
      .reset       (reset),
      .en          (adv),
      .ndc_in      (ndc),
      .half_w      (win_w_ff[pws_pkg::WIN_BITS-1:1]),
      .half_h      (win_h_ff[pws_pkg::WIN_BITS-1:1]),
      .out_valid   (rsp_valid),
      .out_payload (rsp_payload)
   );

   // a waiting result must back-pressure the request side
   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("result stalled but request side not stalled");

   // points with clip w below the visibility threshold carry zero screen coordinates
   a_invis_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.visible |->
         rsp_payload.screen_x == 32'sd0 && rsp_payload.screen_y == 32'sd0)
      else $error("invisible result with nonzero coordinates");

   // window registers come out of reset at their defaults
   a_win_reset: assert property (@(posedge clock)
      $past(reset) && !reset |->
         win_w_ff == pws_pkg::WIN_W_RESET && win_h_ff == pws_pkg::WIN_H_RESET)
      else $error("window registers not at reset value");

endmodule
